[hdl/dmp_pkg.sv]
// Package with the types, constants and helper functions of the DMP Euler step block.
`timescale 1ns / 1ps

package dmp_pkg;

   localparam int CH_W        = 3;
   localparam int DATA_W      = 32;
   localparam int GAIN_W      = 24;
   localparam int COEF_W      = 31;
   localparam int PHASE_W     = 25;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 31;
   localparam int REQ_TDATA_W = 104;
   localparam int RSP_TDATA_W = 96;
   localparam int RSP_PAD_W   = RSP_TDATA_W - CH_W - 2 * DATA_W - PHASE_W;

   localparam int MUL_W  = 34;
   localparam int PROD_W = 2 * MUL_W;
   localparam int TMP_W  = 48;
   localparam int ACC_W  = 52;
   localparam int XSUM_W = 34;
   localparam int VSUM_W = 54;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_STEP = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_STEP_GAIN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_DECAY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STIFFNESS   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DAMPING     = 2'd3;

   localparam logic [GAIN_W-1:0]  STEP_GAIN_RST   = 24'd41943;
   localparam logic [GAIN_W-1:0]  PHASE_DECAY_RST = 24'd20972;
   localparam logic [COEF_W-1:0]  STIFFNESS_RST   = 31'd58982400;
   localparam logic [COEF_W-1:0]  DAMPING_RST     = 31'd2780037;
   localparam logic [PHASE_W-1:0] PHASE_ONE       = 25'h100_0000;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD,
      S_SPRING,
      S_DAMP,
      S_OFFS,
      S_OFFS_LO,
      S_OFFS_HI,
      S_FORCE,
      S_FORCE_LO,
      S_FORCE_HI,
      S_VEL,
      S_ACC_LO,
      S_ACC_HI,
      S_DECAY,
      S_DONE
   } state_type;

   function automatic logic sat_clipped(input logic [VSUM_W-1:0] v);
      return v[VSUM_W-1:DATA_W-1] != {(VSUM_W-DATA_W+1){v[DATA_W-1]}};
   endfunction

   function automatic logic [DATA_W-1:0] sat32(input logic [VSUM_W-1:0] v);
      if (!sat_clipped(v)) begin
         return v[DATA_W-1:0];
      end
      return v[VSUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
   endfunction

endpackage

[hdl/dmp_euler_step.sv]
// Top level of the DMP Euler step block: sequencer around one shared multiplier.
//
//   Channel  Direction  Payload
//   req_*    in         tdata: channel, start_value, goal, forcing; tuser: req_type;
//                       tlast: end_of_tick
//   rsp_*    out        tdata: out_channel, new_position, new_velocity, phase_now;
//                       tuser: saturated
//   csr_*    in         write enable, register index, write data
//
// A step transaction is accepted in S_IDLE, after which the single 34 x 34 bit multiplier
// forms the twelve products in turn, from S_SPRING to S_DECAY, then the result is written in S_DONE.
// A load transaction is accepted and then written in S_LOAD. The block accepts one transaction at a time.
// Reset is synchronous and restores the register defaults, zero channel state and phase one.
// A stalled result holds the sequencer in its final state until the result is taken.
`timescale 1ns / 1ps

module dmp_euler_step #(
   parameter int NUM_CHANNELS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [dmp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dmp_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // channel [2:0], start_value [34:3], goal [66:35], forcing [98:67], zero above
   input  logic [dmp_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // req_type [0]
   input  logic                                req_tuser,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_channel [2:0], new_position [34:3], new_velocity [66:35], phase_now [91:67]
   output logic [dmp_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // saturated [0]
   output logic                                rsp_tuser
);

   import dmp_pkg::*;

   localparam int CH_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   state_type state_ff, state_in;

   logic [GAIN_W-1:0]  step_gain_ff, phase_decay_ff;
   logic [COEF_W-1:0]  stiffness_ff, damping_ff;
   logic [PHASE_W-1:0] phase_ff;

   logic [DATA_W-1:0] start_ff [NUM_CHANNELS];
   logic [DATA_W-1:0] pos_ff   [NUM_CHANNELS];
   logic [DATA_W-1:0] vel_ff   [NUM_CHANNELS];

   logic              type_ff, eot_ff;
   logic [CH_W-1:0]   ch_ff;
   logic [DATA_W-1:0] sv_ff, goal_ff, force_ff;

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic                     mul_en;
   logic signed [PROD_W-1:0] p_ff;
   logic [TMP_W-1:0]         tmp_ff;
   logic [ACC_W-1:0]         acc_ff;
   logic [XSUM_W-1:0]        xsum_ff;
   logic [VSUM_W-1:0]        vsum_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CH_W-1:0]          rsp_ch_ff;
   logic [DATA_W-1:0]        rsp_pos_ff, rsp_vel_ff;
   logic [PHASE_W-1:0]       rsp_phase_ff;
   logic                     rsp_sat_ff;

   logic [CH_AW-1:0]   ch_idx;
   logic               ch_ok;
   logic [DATA_W-1:0]  x_cur, v_cur, x0_cur, diff_base;
   logic [DATA_W:0]    diff;
   logic               out_free, finish, req_fire;
   logic [PHASE_W-1:0] phase_next;
   logic [VSUM_W-1:0]  xsum_ext;
   logic [DATA_W-1:0]  x_sat, v_sat;
   logic               any_clip;

   assign req_fire  = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign finish    = ((state_ff == S_DONE) || (state_ff == S_LOAD)) && out_free;
   assign ch_idx    = CH_AW'({{CH_AW{1'b0}}, ch_ff});
   assign ch_ok     = {{(32 - CH_W){1'b0}}, ch_ff} < 32'(NUM_CHANNELS);
   assign x_cur     = pos_ff[ch_idx];
   assign v_cur     = vel_ff[ch_idx];
   assign x0_cur    = start_ff[ch_idx];
   assign diff_base = (state_ff == S_OFFS) ? x0_cur : x_cur;
   assign diff      = {goal_ff[DATA_W-1], goal_ff} - {diff_base[DATA_W-1], diff_base};

   assign phase_next = eot_ff ? (phase_ff - p_ff[48:24]) : phase_ff;
   assign xsum_ext   = {{(VSUM_W - XSUM_W){xsum_ff[XSUM_W-1]}}, xsum_ff};
   assign x_sat      = sat32(xsum_ext);
   assign v_sat      = sat32(vsum_ff);
   assign any_clip   = sat_clipped(xsum_ext) || sat_clipped(vsum_ff);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_sat_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_phase_ff, rsp_vel_ff, rsp_pos_ff, rsp_ch_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      mul_en   = 1'b1;
      mul_a    = '0;
      mul_b    = '0;
      unique case (state_ff)
         S_IDLE: begin
            mul_en = 1'b0;
            if (req_fire) begin
               state_in = (req_tuser == REQ_LOAD) ? S_LOAD : S_SPRING;
            end
         end
         S_LOAD: begin
            mul_en = 1'b0;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_SPRING: begin
            mul_a    = {{(MUL_W - COEF_W){1'b0}}, stiffness_ff};
            mul_b    = {diff[DATA_W], diff};
            state_in = S_DAMP;
         end
         S_DAMP: begin
            mul_a    = {{(MUL_W - COEF_W){1'b0}}, damping_ff};
            mul_b    = {{(MUL_W - DATA_W){v_cur[DATA_W-1]}}, v_cur};
            state_in = S_OFFS;
         end
         S_OFFS: begin
            mul_a    = {{(MUL_W - COEF_W){1'b0}}, stiffness_ff};
            mul_b    = {diff[DATA_W], diff};
            state_in = S_OFFS_LO;
         end
         S_OFFS_LO: begin
            mul_a    = {{(MUL_W - 24){1'b0}}, p_ff[39:16]};
            mul_b    = {{(MUL_W - PHASE_W){1'b0}}, phase_ff};
            state_in = S_OFFS_HI;
         end
         S_OFFS_HI: begin
            mul_a    = {{(MUL_W - 24){tmp_ff[TMP_W-1]}}, tmp_ff[TMP_W-1:24]};
            mul_b    = {{(MUL_W - PHASE_W){1'b0}}, phase_ff};
            state_in = S_FORCE;
         end
         S_FORCE: begin
            mul_a    = {{(MUL_W - COEF_W){1'b0}}, stiffness_ff};
            mul_b    = {{(MUL_W - DATA_W){force_ff[DATA_W-1]}}, force_ff};
            state_in = S_FORCE_LO;
         end
         S_FORCE_LO: begin
            mul_a    = {{(MUL_W - 24){1'b0}}, p_ff[39:16]};
            mul_b    = {{(MUL_W - PHASE_W){1'b0}}, phase_ff};
            state_in = S_FORCE_HI;
         end
         S_FORCE_HI: begin
            mul_a    = {{(MUL_W - 24){tmp_ff[TMP_W-1]}}, tmp_ff[TMP_W-1:24]};
            mul_b    = {{(MUL_W - PHASE_W){1'b0}}, phase_ff};
            state_in = S_VEL;
         end
         S_VEL: begin
            mul_a    = {{(MUL_W - DATA_W){v_cur[DATA_W-1]}}, v_cur};
            mul_b    = {{(MUL_W - GAIN_W){1'b0}}, step_gain_ff};
            state_in = S_ACC_LO;
         end
         S_ACC_LO: begin
            mul_a    = {{(MUL_W - 24){1'b0}}, acc_ff[23:0]};
            mul_b    = {{(MUL_W - GAIN_W){1'b0}}, step_gain_ff};
            state_in = S_ACC_HI;
         end
         S_ACC_HI: begin
            mul_a    = {{(MUL_W - ACC_W + 24){acc_ff[ACC_W-1]}}, acc_ff[ACC_W-1:24]};
            mul_b    = {{(MUL_W - GAIN_W){1'b0}}, step_gain_ff};
            state_in = S_DECAY;
         end
         S_DECAY: begin
            mul_a    = {{(MUL_W - GAIN_W){1'b0}}, phase_decay_ff};
            mul_b    = {{(MUL_W - PHASE_W){1'b0}}, phase_ff};
            state_in = S_DONE;
         end
         S_DONE: begin
            mul_en = 1'b0;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            mul_en   = 1'b0;
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         p_ff <= mul_a * mul_b;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         type_ff  <= req_tuser;
         eot_ff   <= req_tlast;
         ch_ff    <= req_tdata[2:0];
         sv_ff    <= req_tdata[34:3];
         goal_ff  <= req_tdata[66:35];
         force_ff <= req_tdata[98:67];
      end
      unique case (state_ff)
         S_DAMP:     acc_ff  <= {{(ACC_W - TMP_W){p_ff[63]}}, p_ff[63:16]};
         S_OFFS:     acc_ff  <= acc_ff - {{(ACC_W - TMP_W){p_ff[63]}}, p_ff[63:16]};
         S_OFFS_LO:  tmp_ff  <= p_ff[63:16];
         S_OFFS_HI:  acc_ff  <= acc_ff - {{(ACC_W - PHASE_W){1'b0}}, p_ff[48:24]};
         S_FORCE:    acc_ff  <= acc_ff - p_ff[ACC_W-1:0];
         S_FORCE_LO: tmp_ff  <= p_ff[63:16];
         S_FORCE_HI: acc_ff  <= acc_ff + {{(ACC_W - PHASE_W){1'b0}}, p_ff[48:24]};
         S_VEL:      acc_ff  <= acc_ff + p_ff[ACC_W-1:0];
         S_ACC_LO:   xsum_ff <= {{(XSUM_W - DATA_W){x_cur[DATA_W-1]}}, x_cur}
                               + {p_ff[56], p_ff[56:24]};
         S_ACC_HI:   vsum_ff <= {{(VSUM_W - DATA_W){v_cur[DATA_W-1]}}, v_cur}
                               + {{(VSUM_W - 24){1'b0}}, p_ff[47:24]};
         S_DECAY:    vsum_ff <= vsum_ff + p_ff[VSUM_W-1:0];
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_gain_ff   <= STEP_GAIN_RST;
         phase_decay_ff <= PHASE_DECAY_RST;
         stiffness_ff   <= STIFFNESS_RST;
         damping_ff     <= DAMPING_RST;
         phase_ff       <= PHASE_ONE;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            start_ff[i] <= '0;
            pos_ff[i]   <= '0;
            vel_ff[i]   <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_STEP_GAIN:   step_gain_ff   <= csr_wdata[GAIN_W-1:0];
               CSR_PHASE_DECAY: phase_decay_ff <= csr_wdata[GAIN_W-1:0];
               CSR_STIFFNESS:   stiffness_ff   <= csr_wdata[COEF_W-1:0];
               CSR_DAMPING:     damping_ff     <= csr_wdata[COEF_W-1:0];
               default: begin
               end
            endcase
         end
         if (finish && (state_ff == S_LOAD) && ch_ok) begin
            start_ff[ch_idx] <= sv_ff;
            pos_ff[ch_idx]   <= sv_ff;
            vel_ff[ch_idx]   <= '0;
            phase_ff         <= PHASE_ONE;
         end
         if (finish && (state_ff == S_DONE)) begin
            if (ch_ok) begin
               pos_ff[ch_idx] <= x_sat;
               vel_ff[ch_idx] <= v_sat;
            end
            phase_ff <= phase_next;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_ch_ff <= ch_ff;
         if (type_ff == REQ_LOAD) begin
            rsp_pos_ff   <= ch_ok ? sv_ff : '0;
            rsp_vel_ff   <= '0;
            rsp_phase_ff <= ch_ok ? PHASE_ONE : phase_ff;
            rsp_sat_ff   <= 1'b0;
         end else begin
            rsp_pos_ff   <= ch_ok ? x_sat : '0;
            rsp_vel_ff   <= ch_ok ? v_sat : '0;
            rsp_phase_ff <= phase_next;
            rsp_sat_ff   <= ch_ok && any_clip;
         end
      end
   end

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PHASE_ONE)
      else $error("Phase has risen above one.");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE || state_ff == S_LOAD))
      else $error("A result appeared outside the final sequencer states.");

   a_load_phase: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD && out_free && ch_ok) |=> (phase_ff == PHASE_ONE))
      else $error("A load transaction did not restore the phase to one.");

   a_busy_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !out_free) |=> (state_ff == S_DONE && $stable(phase_ff)))
      else $error("The sequencer left its final state while the result slot was full.");

endmodule
